// ===== rtl/bez_pkg.sv =====
// Shared constants, types and codes for the cubic Bezier easing block.
package bez_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int NEWTON_ITERS = 6;
  localparam int BISECT_ITERS = 24;

  // Datapath widths
  localparam int S_W    = FRAC_BITS + 1;          // curve parameter 0..ONE
  localparam int OPND_W = FRAC_BITS + 3;          // multiplier operand
  localparam int PROD_W = 2 * OPND_W;             // full product
  localparam int SH_W   = PROD_W - FRAC_BITS;     // product after the fraction shift
  localparam int ACC_W  = FRAC_BITS + 7;          // curve value / slope accumulator
  localparam int ERR_W  = ACC_W + 1;              // x(s) - t
  localparam int DNUM_W = ERR_W + FRAC_BITS;      // Newton quotient dividend magnitude
  localparam int QUO_W  = DNUM_W + 1;             // signed Newton quotient
  localparam int DCNT_W = $clog2(DNUM_W);
  localparam int ITER_W = $clog2(NEWTON_ITERS);
  localparam int BCNT_W = $clog2(BISECT_ITERS);
  localparam int IN_W   = 18;
  localparam int OUT_W  = 19;
  localparam int XC_W   = 17;
  localparam int YC_W   = 18;
  localparam int CIDX_W = 2;

  localparam logic [S_W-1:0] ONE_S  = S_W'(1) << FRAC_BITS;
  localparam logic [S_W-1:0] HALF_S = ONE_S >> 1;
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_X1 = 2'd0,
    CFG_Y1 = 2'd1,
    CFG_X2 = 2'd2,
    CFG_Y2 = 2'd3
  } cfg_idx_e;

  // Main sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEWTON,
    ST_DIVIDE,
    ST_BISECT,
    ST_YEVAL
  } ctl_state_e;

  // Evaluator states
  typedef enum logic [1:0] {
    EV_IDLE,
    EV_MUL,
    EV_ACC
  } ev_state_e;

  // Evaluator micro-operations, in issue order
  typedef enum logic [3:0] {
    OP_INV2 = 4'd0,   // inv*inv
    OP_P    = 4'd1,   // (inv*inv)*s
    OP_INVS = 4'd2,   // inv*s
    OP_Q    = 4'd3,   // (inv*s)*s
    OP_S2   = 4'd4,   // s*s
    OP_C    = 4'd5,   // (s*s)*s
    OP_PA   = 4'd6,   // 3*p*a
    OP_QB   = 4'd7,   // 3*q*b, curve value done
    OP_SL0  = 4'd8,   // 3*inv^2*a
    OP_SL1  = 4'd9,   // 6*inv*s*(b-a)
    OP_SL2  = 4'd10   // 3*s^2*(ONE-b), slope done
  } ev_op_e;

  typedef struct packed {
    logic                     go;
    logic                     with_slope;
    logic signed [OPND_W-1:0] a;
    logic signed [OPND_W-1:0] b;
    logic [S_W-1:0]           s;
  } ev_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] val;
    logic signed [ACC_W-1:0] slope;
  } ev_rsp_t;

endpackage

// ===== rtl/bez_eval.sv =====
// Curve value and slope evaluator built around one shared multiplier.
module bez_eval (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bez_pkg::ev_req_t req_i,
  output bez_pkg::ev_rsp_t rsp_o
);
  import bez_pkg::*;

  ev_state_e state_q, state_d;
  ev_op_e    op_q;
  logic      with_slope_q;
  logic      done_q;
  logic      mul_en, acc_en, last_op;

  logic signed [OPND_W-1:0] a_q, b_q, s_q, inv_q;
  logic signed [OPND_W-1:0] r1_q, r2_q, r3_q, p_q, q_q;
  logic signed [OPND_W-1:0] opa, opb, bma, omb;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SH_W-1:0]   sh;
  logic signed [ACC_W-1:0]  sh_x, sh3, sh6;
  logic signed [ACC_W-1:0]  acc_q, sl_q;

  // Shifted product, floor rounding by arithmetic shift
  assign sh   = prod_q[PROD_W-1:FRAC_BITS];
  assign sh_x = ACC_W'(sh);
  assign sh3  = sh_x + (sh_x <<< 1);
  assign sh6  = sh3 <<< 1;
  assign bma  = b_q - a_q;
  assign omb  = OPND_W'(ONE_S) - b_q;

  // Operand select
  always_comb begin
    opa = inv_q;
    opb = inv_q;
    unique case (op_q)
      OP_INV2: begin opa = inv_q; opb = inv_q; end
      OP_P:    begin opa = r1_q;  opb = s_q;   end
      OP_INVS: begin opa = inv_q; opb = s_q;   end
      OP_Q:    begin opa = r2_q;  opb = s_q;   end
      OP_S2:   begin opa = s_q;   opb = s_q;   end
      OP_C:    begin opa = r3_q;  opb = s_q;   end
      OP_PA:   begin opa = p_q;   opb = a_q;   end
      OP_QB:   begin opa = q_q;   opb = b_q;   end
      OP_SL0:  begin opa = r1_q;  opb = a_q;   end
      OP_SL1:  begin opa = r2_q;  opb = bma;   end
      OP_SL2:  begin opa = r3_q;  opb = omb;   end
      default: begin opa = inv_q; opb = inv_q; end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      EV_IDLE: if (req_i.go) state_d = EV_MUL;
      EV_MUL:  state_d = EV_ACC;
      EV_ACC:  state_d = last_op ? EV_IDLE : EV_MUL;
      default: state_d = EV_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    mul_en  = (state_q == EV_MUL);
    acc_en  = (state_q == EV_ACC);
    last_op = with_slope_q ? (op_q == OP_SL2) : (op_q == OP_QB);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EV_IDLE;
      op_q    <= OP_INV2;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= acc_en && last_op;
      if (state_q == EV_IDLE && req_i.go) begin
        op_q <= OP_INV2;
      end else if (acc_en && !last_op) begin
        op_q <= ev_op_e'(op_q + 4'd1);
      end
    end
  end

  // Operand capture and product register
  always_ff @(posedge clk_i) begin
    if (state_q == EV_IDLE && req_i.go) begin
      with_slope_q <= req_i.with_slope;
      a_q          <= req_i.a;
      b_q          <= req_i.b;
      s_q          <= OPND_W'(req_i.s);
      inv_q        <= OPND_W'(ONE_S - req_i.s);
    end
    if (mul_en) begin
      prod_q <= opa * opb;
    end
  end

  // Accumulate results of each micro-operation
  always_ff @(posedge clk_i) begin
    if (acc_en) begin
      unique case (op_q)
        OP_INV2: r1_q  <= sh[OPND_W-1:0];
        OP_P:    p_q   <= sh[OPND_W-1:0];
        OP_INVS: r2_q  <= sh[OPND_W-1:0];
        OP_Q:    q_q   <= sh[OPND_W-1:0];
        OP_S2:   r3_q  <= sh[OPND_W-1:0];
        OP_C:    acc_q <= sh_x;
        OP_PA:   acc_q <= acc_q + sh3;
        OP_QB:   acc_q <= acc_q + sh3;
        OP_SL0:  sl_q  <= sh3;
        OP_SL1:  sl_q  <= sl_q + sh6;
        OP_SL2:  sl_q  <= sl_q + sh3;
        default: ;
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.val   = acc_q;
  assign rsp_o.slope = sl_q;

endmodule

// ===== rtl/bez_div.sv =====
// Radix-2 restoring divider for the Newton step, (num * ONE) / den toward zero.
module bez_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               go_i,
  input  logic signed [bez_pkg::ERR_W-1:0]   num_i,
  input  logic signed [bez_pkg::ACC_W-1:0]   den_i,
  output logic                               done_o,
  output logic signed [bez_pkg::QUO_W-1:0]   quot_o
);
  import bez_pkg::*;

  logic                    run_q, done_q, neg_q;
  logic [DCNT_W-1:0]       cnt_q;
  logic [DNUM_W-1:0]       n_q, n_nxt;
  logic [ACC_W-1:0]        rem_q, dmag_q;
  logic [ERR_W-1:0]        num_mag;
  logic [ACC_W-1:0]        den_mag;
  logic [ACC_W:0]          trial;
  logic                    fits;
  logic signed [QUO_W-1:0] quot_q;

  assign num_mag = num_i[ERR_W-1] ? ERR_W'(-num_i) : ERR_W'(num_i);
  assign den_mag = den_i[ACC_W-1] ? ACC_W'(-den_i) : ACC_W'(den_i);

  // One quotient bit per cycle
  assign trial = {rem_q, n_q[DNUM_W-1]};
  assign fits  = (trial >= {1'b0, dmag_q});
  assign n_nxt = {n_q[DNUM_W-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DCNT_W'(DNUM_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      n_q    <= {num_mag, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      dmag_q <= den_mag;
      neg_q  <= num_i[ERR_W-1] ^ den_i[ACC_W-1];
    end else if (run_q) begin
      n_q   <= n_nxt;
      rem_q <= fits ? ACC_W'(trial - {1'b0, dmag_q}) : trial[ACC_W-1:0];
      if (cnt_q == DCNT_W'(DNUM_W - 1)) begin
        quot_q <= neg_q ? -$signed({1'b0, n_nxt}) : $signed({1'b0, n_nxt});
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/cubic_bezier_easing.sv =====
// Top level: control sequencer, configuration registers and output register.
//
// Cubic Bezier easing (CSS cubic-bezier timing function) in 16-fraction-bit fixed
// point. Pulse start while busy is low to hand in progress_i; the eased value
// appears on eased_value_o for exactly one cycle with done_o high, and must be
// captured then. Progress at or below 0 and at or above 1 finishes the cycle
// after start with 0 or 1. Any other progress runs the solver: each Newton step
// uses the curve/slope evaluator (one shared 19x19 multiplier) and then the
// one-bit-per-cycle divider, each of the 24 bisection steps one curve evaluation,
// and a final y evaluation follows. The fastest case is an exact hit on the first
// Newton evaluation; the worst case is all six Newton steps followed by full
// bisection.
// Configuration writes are always accepted (cfg_ready_o is high) and must only
// be made while busy is low and no result is pending.
module cubic_bezier_easing (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [bez_pkg::IN_W-1:0]    progress_i,
  output logic                               done_o,
  output logic signed [bez_pkg::OUT_W-1:0]   eased_value_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bez_pkg::CIDX_W-1:0]         cfg_index_i,
  input  logic [bez_pkg::YC_W-1:0]           cfg_data_i
);
  import bez_pkg::*;

  ctl_state_e state_q, state_d;

  logic [XC_W-1:0]        x1_q, x2_q;
  logic signed [YC_W-1:0] y1_q, y2_q;

  logic signed [IN_W-1:0] t_q, t_d;
  logic [S_W-1:0]         s_q, s_d, lo_q, lo_d, hi_q, hi_d, s_new, mid;
  logic [ITER_W-1:0]      iter_q, iter_d;
  logic [BCNT_W-1:0]      cnt_q, cnt_d;
  logic                   go_q, go_d, dgo_q, dgo_d, done_q, done_d;
  logic signed [OUT_W-1:0] out_q, out_d, sat_val;

  logic                    accept;
  ev_req_t                 ev_req;
  ev_rsp_t                 ev_rsp;
  logic                    div_done;
  logic signed [QUO_W-1:0] quot;
  logic signed [ERR_W-1:0] err;
  logic signed [QUO_W:0]   diff;
  logic                    err_zero, slope_zero, below;
  logic [S_W:0]            lo_hi_sum;
  logic [S_W-1:0]          nlo, nhi;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Evaluator request
  assign ev_req.go         = go_q;
  assign ev_req.with_slope = (state_q == ST_NEWTON);
  assign ev_req.a = (state_q == ST_YEVAL) ? OPND_W'(y1_q) : OPND_W'($signed({1'b0, x1_q}));
  assign ev_req.b = (state_q == ST_YEVAL) ? OPND_W'(y2_q) : OPND_W'($signed({1'b0, x2_q}));
  assign ev_req.s = s_q;

  bez_eval u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ev_req),
    .rsp_o  (ev_rsp)
  );

  assign err = ERR_W'(ev_rsp.val) - ERR_W'(t_q);

  bez_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (dgo_q),
    .num_i  (err),
    .den_i  (ev_rsp.slope),
    .done_o (div_done),
    .quot_o (quot)
  );

  // Newton update, clamped to 0..ONE
  assign diff = $signed({{(QUO_W + 1 - S_W){1'b0}}, s_q}) - (QUO_W + 1)'(quot);
  always_comb begin
    if (diff < 0) begin
      s_new = '0;
    end else if (diff > $signed((QUO_W + 1)'(ONE_S))) begin
      s_new = ONE_S;
    end else begin
      s_new = diff[S_W-1:0];
    end
  end

  // Bisection bracket update
  assign err_zero   = (err == '0);
  assign slope_zero = (ev_rsp.slope == '0);
  assign below      = (ERR_W'(ev_rsp.val) < ERR_W'(t_q));
  assign nlo        = below ? s_q : lo_q;
  assign nhi        = below ? hi_q : s_q;
  assign lo_hi_sum  = {1'b0, nlo} + {1'b0, nhi};
  assign mid        = lo_hi_sum[S_W:1];

  // Output saturation
  always_comb begin
    if (ev_rsp.val > ACC_W'(OUT_MAX)) begin
      sat_val = OUT_MAX;
    end else if (ev_rsp.val < ACC_W'(OUT_MIN)) begin
      sat_val = OUT_MIN;
    end else begin
      sat_val = ev_rsp.val[OUT_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && progress_i > 0 && progress_i < $signed(IN_W'(ONE_S))) begin
          state_d = ST_NEWTON;
        end
      end
      ST_NEWTON: begin
        if (ev_rsp.done) begin
          priority if (err_zero)   state_d = ST_YEVAL;
          else if (slope_zero)     state_d = ST_BISECT;
          else                     state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_d = (iter_q == ITER_W'(NEWTON_ITERS - 1)) ? ST_BISECT : ST_NEWTON;
        end
      end
      ST_BISECT: begin
        if (ev_rsp.done && cnt_q == BCNT_W'(BISECT_ITERS - 1)) state_d = ST_YEVAL;
      end
      ST_YEVAL: begin
        if (ev_rsp.done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    t_d    = t_q;
    s_d    = s_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    iter_d = iter_q;
    cnt_d  = cnt_q;
    go_d   = 1'b0;
    dgo_d  = 1'b0;
    done_d = 1'b0;
    out_d  = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          t_d = progress_i;
          priority if (progress_i <= 0) begin
            done_d = 1'b1;
            out_d  = '0;
          end else if (progress_i >= $signed(IN_W'(ONE_S))) begin
            done_d = 1'b1;
            out_d  = OUT_W'(ONE_S);
          end else begin
            s_d    = progress_i[S_W-1:0];
            iter_d = '0;
            go_d   = 1'b1;
          end
        end
      end
      ST_NEWTON: begin
        if (ev_rsp.done) begin
          priority if (err_zero) begin
            go_d = 1'b1;
          end else if (slope_zero) begin
            lo_d  = '0;
            hi_d  = ONE_S;
            s_d   = HALF_S;
            cnt_d = '0;
            go_d  = 1'b1;
          end else begin
            dgo_d = 1'b1;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          iter_d = iter_q + 1'b1;
          go_d   = 1'b1;
          if (iter_q == ITER_W'(NEWTON_ITERS - 1)) begin
            lo_d  = '0;
            hi_d  = ONE_S;
            s_d   = HALF_S;
            cnt_d = '0;
          end else begin
            s_d = s_new;
          end
        end
      end
      ST_BISECT: begin
        if (ev_rsp.done) begin
          lo_d  = nlo;
          hi_d  = nhi;
          cnt_d = cnt_q + 1'b1;
          go_d  = 1'b1;
          if (cnt_q != BCNT_W'(BISECT_ITERS - 1)) s_d = mid;
        end
      end
      ST_YEVAL: begin
        if (ev_rsp.done) begin
          done_d = 1'b1;
          out_d  = sat_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      go_q    <= 1'b0;
      dgo_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      dgo_q   <= dgo_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    s_q    <= s_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    iter_q <= iter_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      y1_q <= '0;
      x2_q <= ONE_S;
      y2_q <= YC_W'(ONE_S);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_X1:  x1_q <= cfg_data_i[XC_W-1:0];
        CFG_Y1:  y1_q <= cfg_data_i;
        CFG_X2:  x2_q <= cfg_data_i[XC_W-1:0];
        CFG_Y2:  y2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign done_o        = done_q;
  assign eased_value_o = out_q;

endmodule

// ===== rtl/bez_chk.sv =====
// Port-level checker for the easing block, bound to the top level.
module bez_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic signed [bez_pkg::IN_W-1:0]    progress_i,
  input logic                               done_o,
  input logic signed [bez_pkg::OUT_W-1:0]   eased_value_o
);
  import bez_pkg::*;

  // Progress at or below zero finishes next cycle with zero
  a_low_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && progress_i <= 0) |=> (done_o && eased_value_o == 0))
    else $error("low end result wrong");

  // Progress at or above one finishes next cycle with one
  a_high_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && progress_i >= $signed(IN_W'(ONE_S)))
      |=> (done_o && eased_value_o == $signed(OUT_W'(ONE_S))))
    else $error("high end result wrong");

  // Interior progress starts a solve
  a_solve_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && progress_i > 0 && progress_i < $signed(IN_W'(ONE_S)))
      |=> (busy && !done_o))
    else $error("solve did not start");

  // A result is only shown once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while busy");

endmodule

bind cubic_bezier_easing bez_chk u_bez_chk (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the cubic Bezier easing block.
`timescale 1ns / 1ps

module testbench;
  import bez_pkg::*;

  localparam longint UNIT      = 64'sd1 <<< FRAC_BITS;
  localparam int     MAX_CYCLES = 3_000_000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [IN_W-1:0]   progress_i = '0;
  logic                     done_o;
  logic signed [OUT_W-1:0]  eased_value_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CIDX_W-1:0]        cfg_index_i = '0;
  logic [YC_W-1:0]          cfg_data_i = '0;

  // Predictor copy of the control points
  longint pt_x1, pt_y1, pt_x2, pt_y2;

  logic signed [OUT_W-1:0] eased_queue[$];
  int mismatches = 0;
  int cycle_count = 0;
  int idle_pct = 0;

  cubic_bezier_easing uut (
    .clk_i, .rst_ni, .start, .busy, .progress_i, .done_o, .eased_value_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  // Fixed-point product, floored
  function automatic longint fmul(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint bez_coord(longint a, longint b, longint s);
    longint inv, p, q, c;
    inv = UNIT - s;
    p = fmul(fmul(inv, inv), s);
    q = fmul(fmul(inv, s), s);
    c = fmul(fmul(s, s), s);
    return 3 * fmul(p, a) + 3 * fmul(q, b) + c;
  endfunction

  function automatic longint bez_slope(longint a, longint b, longint s);
    longint inv;
    inv = UNIT - s;
    return 3 * fmul(fmul(inv, inv), a) + 6 * fmul(fmul(inv, s), b - a)
         + 3 * fmul(fmul(s, s), UNIT - b);
  endfunction

  // Solve x(s) = t: Newton first, bisection on failure
  function automatic longint solve_param(longint t);
    longint s, err, slp, lo, hi;
    s = t;
    for (int i = 0; i < NEWTON_ITERS; i++) begin
      err = bez_coord(pt_x1, pt_x2, s) - t;
      if (err == 0) return s;
      slp = bez_slope(pt_x1, pt_x2, s);
      if (slp == 0) break;
      s = s - (err * UNIT) / slp;
      if (s < 0) s = 0;
      if (s > UNIT) s = UNIT;
    end
    lo = 0;
    hi = UNIT;
    for (int i = 0; i < BISECT_ITERS; i++) begin
      s = (lo + hi) >>> 1;
      if (bez_coord(pt_x1, pt_x2, s) < t) lo = s;
      else hi = s;
    end
    return s;
  endfunction

  function automatic logic signed [OUT_W-1:0] eased_of(logic signed [IN_W-1:0] prog);
    longint t, y;
    t = prog;
    if (t <= 0) y = 0;
    else if (t >= UNIT) y = UNIT;
    else y = bez_coord(pt_y1, pt_y2, solve_param(t));
    if (y > 262143) y = 262143;
    if (y < -262144) y = -262144;
    return y[OUT_W-1:0];
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (eased_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", eased_value_o);
      end else begin
        if (eased_value_o !== eased_queue[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("eased_value mismatch: expected %0d, got %0d",
                     eased_queue[0], eased_value_o);
        end
        void'(eased_queue.pop_front());
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("[cubic_bezier_easing] ERROR");
      $finish;
    end
  end

  // Send one progress value; start stays high for back-to-back transactions
  task automatic send_progress(logic signed [IN_W-1:0] prog);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      if (start) start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (!start) start <= 1'b1;
    progress_i <= prog;
    do @(posedge clk_i); while (busy);
    eased_queue.push_back(eased_of(prog));
  endtask

  // Wait until every expected result is in and the block is quiet
  task automatic drain();
    if (start) start <= 1'b0;
    @(posedge clk_i);
    while (eased_queue.size() != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write all four control points while idle
  task automatic load_curve(logic [YC_W-1:0] x1, logic [YC_W-1:0] y1,
                            logic [YC_W-1:0] x2, logic [YC_W-1:0] y2);
    logic [YC_W-1:0] vals[4];
    vals = '{x1, y1, x2, y2};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (cfg_idx_e'(i))
        CFG_X1: pt_x1 = longint'(vals[i][XC_W-1:0]);
        CFG_Y1: pt_y1 = longint'($signed(vals[i]));
        CFG_X2: pt_x2 = longint'(vals[i][XC_W-1:0]);
        CFG_Y2: pt_y2 = longint'($signed(vals[i]));
      endcase
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic sweep_edges();
    send_progress(-18'sd131072);
    send_progress(-18'sd1);
    send_progress(18'sd0);
    send_progress(18'sd1);
    send_progress(18'sd32768);
    send_progress(18'sd65535);
    send_progress(18'sd65536);
    send_progress(18'sd131071);
  endtask

  // Reset curve is linear: ends, clamping and a midpoint
  task automatic test_reset_curve();
    sweep_edges();
  endtask

  // Extreme curves: flat start slope, overshooting x, y saturation range
  task automatic test_extreme_curves();
    load_curve(18'd0, 18'h20000, 18'd0, 18'h1FFFF);
    sweep_edges();
    load_curve(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 18'h20000);
    sweep_edges();
    drain();
  endtask

  function automatic logic [YC_W-1:0] pick_x();
    case ($urandom_range(5))
      0: return 18'd0;
      1: return 18'd65536;
      2: return YC_W'($urandom_range(0, 18'h3FFFF));
      default: return YC_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [YC_W-1:0] pick_y();
    case ($urandom_range(5))
      0: return 18'h1FFFF;
      1: return 18'h20000;
      2: return YC_W'($urandom_range(0, 18'h3FFFF));
      default: return 18'($signed($urandom_range(0, 196608)) - 65536);
    endcase
  endfunction

  function automatic logic signed [IN_W-1:0] pick_progress();
    if ($urandom_range(9) < 2) return IN_W'($urandom_range(0, 18'h3FFFF));
    return IN_W'($urandom_range(1, 65535));
  endfunction

  // Random curves and progress through the idling phases
  task automatic test_random();
    int pcts[4];
    pcts = '{0, 76, 76, 24};
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = pcts[ph];
      for (int c = 0; c < 4; c++) begin
        load_curve(pick_x(), pick_y(), pick_x(), pick_y());
        for (int n = 0; n < 43; n++) begin
          send_progress(pick_progress());
          // occasionally hold off until all results are in
          if (n == 20 && c == 0) drain();
        end
      end
    end
  endtask

  initial begin
    pt_x1 = 0;
    pt_y1 = 0;
    pt_x2 = UNIT;
    pt_y2 = UNIT;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_curve();
    test_extreme_curves();
    test_random();
    drain();
    if (mismatches == 0) begin
      $display("[cubic_bezier_easing] OK");
    end else begin
      $display("[cubic_bezier_easing] ERROR");
    end
    $finish;
  end

endmodule
